>>> hdl/geodetic_to_ecef_defines.svh
// assertion macros for the geodetic to ecef block
// used by files that check their own pipeline control; expects clk_i and rst_ni in scope
`ifndef GEODETIC_TO_ECEF_DEFINES_SVH
`define GEODETIC_TO_ECEF_DEFINES_SVH

// same-cycle implication
`define G2E_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define G2E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/g2e_pkg.sv
// shared types, constants and the arctangent table for the geodetic to ecef block
// no dependencies
`timescale 1ns / 1ps

package g2e_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 29;

  // field widths
  localparam int unsigned LAT_W = 31;
  localparam int unsigned LON_W = 32;
  localparam int unsigned H_W   = 28;
  localparam int unsigned OUT_W = 34;

  // datapath widths and step counts
  localparam int unsigned CW           = 34;
  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned SQRT_STEPS   = 31;
  localparam int unsigned SQ_W         = 62;
  localparam int unsigned DIV_STEPS    = 34;
  localparam int unsigned DIV_W        = 64;
  localparam int unsigned R_W          = 31;

  // angle and ellipsoid constants, q30 radians and mm
  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
  localparam logic [63:0] PI_Q30        = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q30    = 64'd6746518852;
  localparam logic [63:0] ONE_Q30       = 64'd1073741824;
  localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;
  localparam logic [63:0] DIVIDEND      = SEMI_MAJOR_MM << 31;
  localparam logic [32:0] E2_Q40        = 33'd7360548640;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [R_W-1:0]       r;
    logic [DIV_STEPS-1:0] q;
  } div_t;

  // truncated q30 arctangent of 2^-i
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000007;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    atan_q30 = $signed({2'b00, v});
  endfunction

endpackage

>>> hdl/g2e_delay.sv
// registered delay line with a shared advance enable
// depends on nothing
`timescale 1ns / 1ps

module g2e_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // shift one place per advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

>>> hdl/g2e_cordic_cell.sv
// one rotation-mode cordic iteration with its output register
// depends on g2e_pkg
`timescale 1ns / 1ps

module g2e_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  g2e_pkg::cordic_t vec_i,
  output g2e_pkg::cordic_t vec_o
);
  import g2e_pkg::*;

  localparam logic signed [CW-1:0] ATAN = atan_q30(STEP);

  logic signed [CW-1:0] dx, dy;
  cordic_t vec_d, vec_q;

  // floor shifts
  assign dx = vec_i.y >>> STEP;
  assign dy = vec_i.x >>> STEP;

  // rotate toward zero residual angle
  always_comb begin
    if (!vec_i.z[CW-1]) begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - ATAN;
    end else begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule

>>> hdl/g2e_sqrt_cell.sv
// one digit of the integer square root, registered
// depends on g2e_pkg
`timescale 1ns / 1ps

module g2e_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  g2e_pkg::sqrt_t vec_i,
  output g2e_pkg::sqrt_t vec_o
);
  import g2e_pkg::*;

  localparam int unsigned POS = 2 * (SQRT_STEPS - 1 - STEP);
  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << POS;

  logic [SQ_W-1:0] trial;
  sqrt_t vec_d, vec_q;

  assign trial = vec_i.res + BIT;

  // try this digit
  always_comb begin
    if (vec_i.rem >= trial) begin
      vec_d.rem = vec_i.rem - trial;
      vec_d.res = (vec_i.res >> 1) + BIT;
    end else begin
      vec_d.rem = vec_i.rem;
      vec_d.res = vec_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule

>>> hdl/g2e_div_cell.sv
// one quotient bit of the restoring divider, registered
// depends on g2e_pkg
`timescale 1ns / 1ps

module g2e_div_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  g2e_pkg::div_t vec_i,
  output g2e_pkg::div_t vec_o
);
  import g2e_pkg::*;

  logic [DIV_W-1:0] dsr;
  div_t vec_d, vec_q;

  assign dsr = DIV_W'(vec_i.r) << BIT_POS;

  // compare and subtract shifted divisor
  always_comb begin
    vec_d = vec_i;
    if (vec_i.rem >= dsr) begin
      vec_d.rem        = vec_i.rem - dsr;
      vec_d.q[BIT_POS] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule

>>> hdl/geodetic_to_ecef.sv
// geodetic to ecef conversion on the wgs84 ellipsoid, fully pipelined top level
// depends on g2e_pkg, g2e_delay, g2e_cordic_cell, g2e_sqrt_cell, g2e_div_cell
//
//  channel   handshake                 payload
//  input     in_valid_i / in_ready_o   latitude_i, longitude_i, height_mm_i
//  output    out_valid_o / out_ready_i ecef_x_o, ecef_y_o, ecef_z_o
//
// one item per cycle sustained while results are taken; the path up to the output
// register is the longitude wrap, two 32-cell cordic rows, 31-cell root, 34-cell divider,
// product stages. reset clears all stage valid bits and the output valid.
// the whole pipe holds only when its last stage has an item and the output register
// is full and not taken; bubbles in the pipe let items enter while a result waits.
`timescale 1ns / 1ps
`include "geodetic_to_ecef_defines.svh"

module geodetic_to_ecef #(
  parameter int unsigned ANGLE_FRAC_BITS = g2e_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [g2e_pkg::LAT_W-1:0]   latitude_i,
  input  logic signed [g2e_pkg::LON_W-1:0]   longitude_i,
  input  logic signed [g2e_pkg::H_W-1:0]     height_mm_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [g2e_pkg::OUT_W-1:0]   ecef_x_o,
  output logic signed [g2e_pkg::OUT_W-1:0]   ecef_y_o,
  output logic signed [g2e_pkg::OUT_W-1:0]   ecef_z_o
);
  import g2e_pkg::*;

  localparam int unsigned SH     = 30 - ANGLE_FRAC_BITS;
  localparam int unsigned KW     = SH + 1;
  localparam int unsigned LAT_SW = 33 + SH;
  localparam int unsigned MW     = 36 + SH;
  localparam int unsigned TOTAL  = KW + 110;
  localparam int unsigned SQ_IDX = KW + 68;
  localparam int unsigned PX_IDX = KW + 105;

  localparam logic signed [LAT_SW-1:0] LAT_MAX = LAT_SW'(HALF_PI_Q30);
  localparam logic signed [MW-1:0]     LON_PI  = MW'(PI_Q30);
  localparam logic signed [MW-1:0]     LON_OFS = MW'(TWO_PI_Q30 << SH);
  localparam logic signed [CW-1:0]     C_HALF  = CW'(HALF_PI_Q30);
  localparam logic signed [CW-1:0]     C_PI    = CW'(PI_Q30);

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    mag = v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // pipeline control
  logic             en;
  logic [TOTAL-1:0] vld_q;
  logic             out_valid_q;
  logic             out_load;

  assign en         = !(vld_q[TOTAL-1] && out_valid_q && !out_ready_i);
  assign in_ready_o = en;
  assign out_load   = en && vld_q[TOTAL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) vld_q <= {vld_q[TOTAL-2:0], in_valid_i};
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // input scaling, latitude clamp, longitude offset for the wrap
  logic signed [LAT_SW-1:0] lat_s;
  logic signed [CW-1:0]     lat_c, lat_f;
  logic signed [MW-1:0]     lon_s;
  logic                     inr_c, inr_f;
  logic signed [CW-1:0]     lonraw_f;
  logic signed [H_W-1:0]    h_m1;
  logic signed [MW-1:0]     wm_q [KW+1];

  assign lat_s = LAT_SW'(latitude_i) <<< SH;
  assign lon_s = MW'(longitude_i) <<< SH;
  assign inr_c = (lon_s <= LON_PI) && (lon_s >= -LON_PI);

  always_comb begin
    if (lat_s > LAT_MAX) lat_c = CW'(LAT_MAX);
    else if (lat_s < -LAT_MAX) lat_c = CW'(-LAT_MAX);
    else lat_c = CW'(lat_s);
  end

  always_ff @(posedge clk_i) begin
    if (en) wm_q[0] <= lon_s + LON_PI + LON_OFS;
  end

  g2e_delay #(.WIDTH(CW), .DEPTH(KW + 2)) u_lat_dly (
    .clk_i(clk_i), .en_i(en), .d_i(lat_c), .q_o(lat_f)
  );

  g2e_delay #(.WIDTH(CW + 1), .DEPTH(KW + 1)) u_lon_dly (
    .clk_i(clk_i), .en_i(en), .d_i({inr_c, CW'(lon_s)}), .q_o({inr_f, lonraw_f})
  );

  g2e_delay #(.WIDTH(H_W), .DEPTH(KW + 105)) u_h_dly (
    .clk_i(clk_i), .en_i(en), .d_i(height_mm_i), .q_o(h_m1)
  );

  // longitude wrap, one multiple of two pi per stage
  for (genvar j = 0; j < KW; j++) begin : g_wrap
    localparam logic signed [MW-1:0] SUB = MW'(TWO_PI_Q30 << (KW - 1 - j));
    always_ff @(posedge clk_i) begin
      if (en) wm_q[j+1] <= (wm_q[j] >= SUB) ? wm_q[j] - SUB : wm_q[j];
    end
  end

  // fold longitude into a quarter turn
  logic signed [CW-1:0] lonr, lon_fd, lon_fq;
  logic                 flip_d, flip_q, flip_c;

  assign lonr = inr_f ? lonraw_f : CW'(wm_q[KW] - LON_PI);

  always_comb begin
    if (lonr > C_HALF) begin
      lon_fd = lonr - C_PI;
      flip_d = 1'b1;
    end else if (lonr < -C_HALF) begin
      lon_fd = lonr + C_PI;
      flip_d = 1'b1;
    end else begin
      lon_fd = lonr;
      flip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lon_fq <= lon_fd;
      flip_q <= flip_d;
    end
  end

  g2e_delay #(.WIDTH(1), .DEPTH(CORDIC_STEPS)) u_flip_dly (
    .clk_i(clk_i), .en_i(en), .d_i(flip_q), .q_o(flip_c)
  );

  // two cordic rows
  cordic_t lat_v [CORDIC_STEPS+1];
  cordic_t lon_v [CORDIC_STEPS+1];

  assign lat_v[0] = '{x: CORDIC_GAIN, y: '0, z: lat_f};
  assign lon_v[0] = '{x: CORDIC_GAIN, y: '0, z: lon_fq};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    g2e_cordic_cell #(.STEP(i)) u_lat (
      .clk_i(clk_i), .en_i(en), .vec_i(lat_v[i]), .vec_o(lat_v[i+1])
    );
    g2e_cordic_cell #(.STEP(i)) u_lon (
      .clk_i(clk_i), .en_i(en), .vec_i(lon_v[i]), .vec_o(lon_v[i+1])
    );
  end

  // magnitudes and result signs
  logic signed [CW-1:0] clat, slat, clon, slon;
  logic [CW-1:0]        slat_mag, clat_mag, clon_mag, slon_mag;
  logic [30:0]          sa_d, sa_q;
  logic [2:0]           sgn_c, sgn_m6;
  logic [31:0]          clat_m, slat_m, clon_m, slon_m;

  assign clat     = lat_v[CORDIC_STEPS].x;
  assign slat     = lat_v[CORDIC_STEPS].y;
  assign clon     = lon_v[CORDIC_STEPS].x;
  assign slon     = lon_v[CORDIC_STEPS].y;
  assign slat_mag = mag(slat);
  assign clat_mag = mag(clat);
  assign clon_mag = mag(clon);
  assign slon_mag = mag(slon);
  assign sa_d     = (slat_mag > CW'(ONE_Q30)) ? 31'(ONE_Q30) : slat_mag[30:0];
  assign sgn_c    = {clat[CW-1] ^ clon[CW-1] ^ flip_c,
                     clat[CW-1] ^ slon[CW-1] ^ flip_c,
                     slat[CW-1]};

  g2e_delay #(.WIDTH(64), .DEPTH(72)) u_lat_mag_dly (
    .clk_i(clk_i), .en_i(en), .d_i({clat_mag[31:0], slat_mag[31:0]}),
    .q_o({clat_m, slat_m})
  );

  g2e_delay #(.WIDTH(64), .DEPTH(74)) u_lon_mag_dly (
    .clk_i(clk_i), .en_i(en), .d_i({clon_mag[31:0], slon_mag[31:0]}),
    .q_o({clon_m, slon_m})
  );

  g2e_delay #(.WIDTH(3), .DEPTH(76)) u_sgn_dly (
    .clk_i(clk_i), .en_i(en), .d_i(sgn_c), .q_o(sgn_m6)
  );

  // one minus e2 sin squared
  logic [61:0] s2_q;
  logic [64:0] t_prod;
  logic [33:0] t_q;
  logic [40:0] w_q;

  assign t_prod = 65'(E2_Q40) * 65'(s2_q[60:29]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q <= sa_d;
      s2_q <= 62'(sa_q) * 62'(sa_q);
      t_q  <= t_prod[64:31];
      w_q  <= (41'(1) << 40) - 41'(t_q);
    end
  end

  // square root row
  sqrt_t sq_v [SQRT_STEPS+1];
  logic [R_W-1:0] root, root_g;

  assign sq_v[0] = '{rem: SQ_W'({w_q, 20'b0}), res: '0};

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    g2e_sqrt_cell #(.STEP(i)) u_sq (
      .clk_i(clk_i), .en_i(en), .vec_i(sq_v[i]), .vec_o(sq_v[i+1])
    );
  end

  assign root   = sq_v[SQRT_STEPS].res[R_W-1:0];
  assign root_g = (root == '0) ? R_W'(1) : root;

  // divider row for the prime vertical radius
  div_t dv_v [DIV_STEPS+1];

  assign dv_v[0] = '{rem: DIVIDEND, r: root_g, q: '0};

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    g2e_div_cell #(.BIT_POS(DIV_STEPS - 1 - i)) u_dv (
      .clk_i(clk_i), .en_i(en), .vec_i(dv_v[i]), .vec_o(dv_v[i+1])
    );
  end

  // product stages
  logic [49:0]        ne_hi_q, ne_lo_q;
  logic [33:0]        n0_q, n1_q;
  logic [67:0]        ne_sum;
  logic [27:0]        e_q;
  logic signed [35:0] px_q, qz_q;
  logic [48:0]        p1_hi_q, p1_lo_q, z_hi_q, z_lo_q;
  logic [66:0]        p1_sum, z_sum;
  logic [34:0]        p1_q, zm4_q, zm5_q, zm6_q, xm_q, ym_q;
  logic [49:0]        x_hi_q, x_lo_q, y_hi_q, y_lo_q;
  logic [67:0]        x_sum, y_sum;

  assign ne_sum = (68'(ne_hi_q) << 17) + 68'(ne_lo_q) + (68'(1) << 39);
  assign p1_sum = (67'(p1_hi_q) << 17) + 67'(p1_lo_q) + (67'(1) << 29);
  assign z_sum  = (67'(z_hi_q) << 17) + 67'(z_lo_q) + (67'(1) << 30);
  assign x_sum  = (68'(x_hi_q) << 17) + 68'(x_lo_q) + (68'(1) << 30);
  assign y_sum  = (68'(y_hi_q) << 17) + 68'(y_lo_q) + (68'(1) << 30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // n times e2
      ne_hi_q <= 50'(dv_v[DIV_STEPS].q[33:17]) * 50'(E2_Q40);
      ne_lo_q <= 50'(dv_v[DIV_STEPS].q[16:0]) * 50'(E2_Q40);
      n0_q    <= dv_v[DIV_STEPS].q;
      e_q     <= ne_sum[67:40];
      n1_q    <= n0_q;
      // radius sums in half millimetres
      px_q    <= $signed({2'b00, n1_q}) + (36'(h_m1) <<< 1);
      qz_q    <= $signed({2'b00, n1_q}) - $signed({8'b0, e_q}) + (36'(h_m1) <<< 1);
      // first products
      p1_hi_q <= 49'(px_q[33:17]) * 49'(clat_m);
      p1_lo_q <= 49'(px_q[16:0]) * 49'(clat_m);
      z_hi_q  <= 49'(qz_q[33:17]) * 49'(slat_m);
      z_lo_q  <= 49'(qz_q[16:0]) * 49'(slat_m);
      p1_q    <= p1_sum[64:30];
      zm4_q   <= z_sum[65:31];
      // longitude products
      x_hi_q  <= 50'(p1_q[34:17]) * 50'(clon_m);
      x_lo_q  <= 50'(p1_q[16:0]) * 50'(clon_m);
      y_hi_q  <= 50'(p1_q[34:17]) * 50'(slon_m);
      y_lo_q  <= 50'(p1_q[16:0]) * 50'(slon_m);
      zm5_q   <= zm4_q;
      xm_q    <= x_sum[65:31];
      ym_q    <= y_sum[65:31];
      zm6_q   <= zm5_q;
    end
  end

  // output register with signs restored
  logic [34:0] x_sd, y_sd, z_sd;
  logic signed [OUT_W-1:0] ecef_x_q, ecef_y_q, ecef_z_q;

  assign x_sd = sgn_m6[2] ? 35'(0) - xm_q : xm_q;
  assign y_sd = sgn_m6[1] ? 35'(0) - ym_q : ym_q;
  assign z_sd = sgn_m6[0] ? 35'(0) - zm6_q : zm6_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ecef_x_q <= $signed(x_sd[OUT_W-1:0]);
      ecef_y_q <= $signed(y_sd[OUT_W-1:0]);
      ecef_z_q <= $signed(z_sd[OUT_W-1:0]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ecef_x_o    = ecef_x_q;
  assign ecef_y_o    = ecef_y_q;
  assign ecef_z_o    = ecef_z_q;

  // checks
  `G2E_ASSERT(a_stall_blocks_input, vld_q[TOTAL-1] && out_valid_q && !out_ready_i,
              !in_ready_o, "pipe took an item while blocked")
  `G2E_ASSERT_NEXT(a_item_enters, in_valid_i && in_ready_o, vld_q[0],
                   "accepted item lost at entry")
  `G2E_ASSERT_NEXT(a_result_lands, out_load, out_valid_q,
                   "finished item not in output register")
  `G2E_ASSERT(a_root_nonzero, vld_q[SQ_IDX], root != '0, "square root came out zero")
  `G2E_ASSERT(a_radius_positive, vld_q[PX_IDX], !px_q[35] && !qz_q[35],
              "radius sum went negative")

endmodule

>>> bench/tb_top.sv
// self-checking bench for the geodetic to ecef block, wgs84 fixed point
// depends on g2e_pkg and the geodetic_to_ecef top level
`timescale 1ns / 1ps

module tb_top;
  import g2e_pkg::*;

  localparam int unsigned FRAC     = 29;
  localparam int          WD_LIMIT = 4000;
  localparam int          LATENCY  = 141 - FRAC;
  localparam longint      HALF_PI  = 64'sd1686629713;
  localparam longint      PI_Q     = 64'sd3373259426;
  localparam longint      TWO_PI   = 64'sd6746518852;
  localparam longint      E2       = 64'sd7360548640;
  localparam longint      GAIN     = 64'sd652032874;
  localparam longint      ONE      = 64'sd1073741824;
  localparam longint unsigned A_MM = 64'd6378137000;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
  } ecef_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [LAT_W-1:0] latitude_i = '0;
  logic signed [LON_W-1:0] longitude_i = '0;
  logic signed [H_W-1:0] height_mm_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] ecef_x_o, ecef_y_o, ecef_z_o;

  ecef_t expected_ecef[$];
  int mismatches = 0;
  int positions_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  int rx_wait = 0;

  longint atan_tab[32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
    64'h00000000, 64'h00000000};

  geodetic_to_ecef dut (.*);

  always #5 clk_i = ~clk_i;

  // rounded magnitude product, half up
  function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    return p[63+s -: 64];
  endfunction

  // symmetric rounding on signed operands
  function automatic longint mul_sym(longint a, longint b, int s);
    longint r;
    r = mul_round(a < 0 ? -a : a, b < 0 ? -b : b, s);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // rotation-mode cordic, q30
  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = GAIN;
    y = 0;
    z = ang;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = x;
    s = y;
  endtask

  task automatic compute_ecef(input logic signed [LAT_W-1:0] lat_in,
                              input logic signed [LON_W-1:0] lon_in,
                              input logic signed [H_W-1:0] h_in, output ecef_t res);
    longint lat, lon, h, m, clat, slat, clon, slon, sa, px, qz, p1;
    longint unsigned s2, t, w, r, n;
    bit flip;
    lat = longint'(lat_in) <<< (30 - FRAC);
    lon = longint'(lon_in) <<< (30 - FRAC);
    h = longint'(h_in);
    flip = 1'b0;
    // saturate latitude, wrap and fold longitude
    if (lat > HALF_PI) lat = HALF_PI;
    if (lat < -HALF_PI) lat = -HALF_PI;
    if (lon > PI_Q || lon < -PI_Q) begin
      m = (lon + PI_Q) % TWO_PI;
      if (m < 0) m += TWO_PI;
      lon = m - PI_Q;
    end
    if (lon > HALF_PI) begin
      lon -= PI_Q; flip = 1'b1;
    end else if (lon < -HALF_PI) begin
      lon += PI_Q; flip = 1'b1;
    end
    sin_cos(lat, clat, slat);
    sin_cos(lon, clon, slon);
    if (flip) begin
      clon = -clon; slon = -slon;
    end
    // prime vertical radius
    sa = slat < 0 ? -slat : slat;
    if (sa > ONE) sa = ONE;
    s2 = sa * sa;
    t = (longint'(E2) * (s2 >> 29)) >> 31;
    w = (64'd1 << 40) - t;
    r = int_sqrt(w << 20);
    if (r == 0) r = 1;
    n = (A_MM << 31) / r;
    px = longint'(n) + 2 * h;
    qz = longint'(n) - longint'(mul_round(n, E2, 40)) + 2 * h;
    p1 = mul_sym(px, clat, 30);
    res.x = OUT_W'(mul_sym(p1, clon, 31));
    res.y = OUT_W'(mul_sym(p1, slon, 31));
    res.z = OUT_W'(mul_sym(qz, slat, 31));
  endtask

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // drive one position, hold until taken
  task automatic send_position(input longint lat, input longint lon, input longint h);
    ecef_t e;
    int gap;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;
    logic signed [H_W-1:0] h_b;
    lat_b = LAT_W'(lat);
    lon_b = LON_W'(lon);
    h_b = H_W'(h);
    compute_ecef(lat_b, lon_b, h_b, e);
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    latitude_i <= lat_b;
    longitude_i <= lon_b;
    height_mm_i <= h_b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_ecef.push_back(e);
    positions_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_ecef.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_position(0, 0, 0);
    send_position(843314857, 0, 0);
    send_position(-843314857, 0, 0);
    send_position(0, 1686629713, 0);
    send_position(0, -1686629713, 0);
    send_position(0, 843314857, 100000000);
    send_position(0, -843314857, -10000000);
    send_position(843314857, 1686629713, 100000000);
    send_position(-843314857, -1686629713, -10000000);
    send_position(421657428, 421657428, 12345);
  endtask

  task automatic test_special_cases();
    // latitude past the pole saturates
    send_position(31'sh3FFFFFFF, 0, 0);
    send_position(-31'sh40000000, 5, 0);
    // longitude past a quarter turn folds, past a half turn wraps
    send_position(100000000, 843314858, 1000);
    send_position(-100000000, -843314858, 1000);
    send_position(200000000, 1686629714, 0);
    send_position(200000000, -1686629714, 0);
    send_position(300000000, 32'sh7FFFFFFF, 0);
    send_position(300000000, -32'sh80000000, 0);
    // height at the limits of its field is used as given
    send_position(500000000, 700000000, 28'sh7FFFFFF);
    send_position(-500000000, -700000000, -28'sh8000000);
  endtask

  task automatic test_random(int count);
    longint lat, lon, h;
    for (int i = 0; i < count; i++) begin
      no_idle = ((i / 150) % 4) == 3;
      if ($urandom_range(0, 99) < 85) begin
        lat = longint'($urandom_range(0, 2 * 843314857)) - 843314857;
        lon = longint'($urandom_range(0, 32'd3373259426)) - 1686629713;
        h = longint'($urandom_range(0, 110000000)) - 10000000;
      end else begin
        lat = longint'($urandom());
        lon = longint'($urandom());
        h = longint'($urandom());
      end
      send_position(lat, lon, h);
    end
    no_idle = 1'b0;
  endtask

  // result sink with random stalls
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) rx_wait = draw_wait();
    else if (rx_wait > 0) rx_wait--;
    out_ready_i <= (rx_wait == 0);
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    ecef_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_ecef.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d", ecef_x_o);
      end else begin
        e = expected_ecef.pop_front();
        if (e.x !== ecef_x_o || e.y !== ecef_y_o || e.z !== ecef_z_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h got %h %h %h",
                     e.x, e.y, e.z, ecef_x_o, ecef_y_o, ecef_z_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    wait_drained();
    test_random(1200);
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("sent %0d positions, checked %0d results, %0d mismatches",
             positions_sent, results_seen, mismatches);
    $display("covered range extremes, pole saturation, longitude fold and wrap, random stalls");
    if (mismatches == 0 && expected_ecef.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
